[sv/stq_pkg.sv]
// Shared types, codes and helpers for the sorted timer queue.
// No dependencies.
package stq_pkg;

    localparam int MAX_FIRE = 16;
    localparam int FIRE_IW  = 4;
    localparam int TIME_W   = 48;
    localparam int FS_W     = 39;
    localparam int DIV_STEPS = 6;
    localparam logic [10:0] MS_PER_S = 11'd1000;
    // ceil(2^36 / 1000): exact quotient by 1000 for any 26-bit dividend
    localparam logic [26:0] RECIP_MS = 27'd68719477;
    localparam int RECIP_SHIFT = 36;

    localparam logic [1:0] CMD_SCHED  = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;
    localparam logic [1:0] CMD_EXPIRE = 2'd3;

    localparam logic [2:0] KIND_ID      = 3'd0;
    localparam logic [2:0] KIND_DONE    = 3'd1;
    localparam logic [2:0] KIND_FIRED   = 3'd2;
    localparam logic [2:0] KIND_SUMMARY = 3'd3;
    localparam logic [2:0] KIND_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] now_ms;
        logic [30:0] delay_ms;
        logic signed [31:0] period_ms;
        logic [31:0] timer_id;
        logic [31:0] task_tag;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] out_id;
        logic [31:0] out_task;
        logic [38:0] fire_time_s;
        logic [4:0]  expired_count;
        logic        last;
    } out_beat_t;

    // command as handed from front to back
    typedef struct packed {
        in_beat_t    beat;
        logic [38:0] fs;
    } work_t;

    typedef struct packed {
        logic [47:0] expiry;
        logic [31:0] period;
        logic [31:0] ident;
        logic [31:0] tag;
    } slot_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_FULL,
        B_FIND,
        B_INSERT,
        B_ID,
        B_SEARCH,
        B_DONE,
        B_FIRE,
        B_REIN,
        B_SUM
    } back_state_t;

    // now + interval, saturating at the top of the 48-bit time range
    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

endpackage

[sv/sorted_timer_queue_unit.sv]
// Top level of the sorted timer queue: front, queue and back joined.
// Depends on stq_pkg, stq_front, stq_fifo, stq_back.
//
//   channel | direction | payload     | handshake
//   in      | into      | in_beat_t   | in_valid / in_stall
//   out     | out of    | out_beat_t  | out_valid / out_stall
//
// Work: schedule, cancel and reset scan the table in the back, one table slot
// compared per cycle; an expire check first runs the front divider (per
// 16-bit chunk of now_ms: reciprocal multiply, then remainder), then fires
// timers one per cycle while the output is not stalled, plus a slot scan per
// repeating timer that is reinserted.
// Reset: async, active low; clears table fill count and id counter, slot
// contents stay undefined. No clearing pass.
// Stalls: the front takes one beat at a time; a two-entry queue lets the
// front work on the next beat while the back scans; the back holds while the
// output register is full and stalled.
module sorted_timer_queue_unit
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_beat,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_beat
);

    logic  push_valid, push_stall;
    work_t push_work;
    logic  pop_valid, pop_take;
    work_t pop_work;

    stq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_beat    (in_beat),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_work  (push_work)
    );

    stq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_work  (push_work),
        .pop_valid  (pop_valid),
        .pop_take   (pop_take),
        .pop_work   (pop_work)
    );

    stq_back #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_take  (pop_take),
        .pop_work  (pop_work),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

endmodule

[sv/stq_front.sv]
// Front end: accepts command beats and works out seconds for expire checks.
// Depends on stq_pkg.
module stq_front
    import stq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_beat_t in_beat,
    output logic     push_valid,
    input  logic     push_stall,
    output work_t    push_work
);

    front_state_t state_reg, state_next;
    in_beat_t     item_reg;
    logic [47:0]  dvd_reg, dvd_next;
    logic [9:0]   rem_reg, rem_next;
    logic [15:0]  qch_reg, qch_next;
    logic [2:0]   step_reg, step_next;
    logic [25:0]  part;
    logic [52:0]  prod;
    logic [25:0]  back_mul;
    logic [25:0]  part_rem;

    // divide by 1000 in 16-bit chunks, top chunk first; for each chunk a
    // reciprocal multiply for the chunk quotient, then the remainder
    always_comb
    begin
        part      = {rem_reg, dvd_reg[47:32]};
        prod      = {27'b0, part} * {26'b0, RECIP_MS};
        qch_next  = prod[RECIP_SHIFT+15:RECIP_SHIFT];
        back_mul  = {10'b0, qch_reg} * 26'(MS_PER_S);
        part_rem  = part - back_mul;
        rem_next  = part_rem[9:0];
        dvd_next  = {dvd_reg[31:0], qch_reg};
        step_next = step_reg + 3'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                    state_next = (in_beat.cmd == CMD_EXPIRE) ? F_DIV : F_PUSH;
            end
            F_DIV:
            begin
                if (step_reg == 3'(DIV_STEPS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!push_stall)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall       = (state_reg != F_IDLE);
        push_valid     = (state_reg == F_PUSH);
        push_work.beat = item_reg;
        push_work.fs   = dvd_reg[38:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            item_reg <= in_beat;
            dvd_reg  <= in_beat.now_ms;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            step_reg <= step_next;
            if (!step_reg[0])
                qch_reg <= qch_next;
            else
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
            end
        end
    end

endmodule

[sv/stq_fifo.sv]
// Two-entry queue between front and back.
// Depends on stq_pkg.
module stq_fifo
    import stq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_stall,
    input  work_t push_work,
    output logic  pop_valid,
    input  logic  pop_take,
    output work_t pop_work
);

    work_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_stall = (cnt_reg == 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_work   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && pop_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_work;
    end

endmodule

[sv/stq_back.sv]
// Back end: sorted timer table, one slot scanned per cycle, result register.
// Depends on stq_pkg.
module stq_back
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_take,
    input  work_t     pop_work,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_beat
);

    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    back_state_t  state_reg, state_next;
    work_t        cmd_reg;
    slot_t        slot_reg [TIMER_SLOTS];
    slot_t        fbuf_reg [MAX_FIRE];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_reg;
    logic [4:0]   nfire_reg;
    logic [4:0]   rin_reg;
    logic [31:0]  id_reg;
    slot_t        ins_reg;
    logic         ret_reg;
    out_beat_t    out_reg;
    logic         out_valid_reg;

    slot_t        scan_slot;
    slot_t        rein_slot;
    logic         can_emit;
    logic         scan_live;
    logic         emit;
    out_beat_t    emit_beat;
    logic         fire_due;
    logic         rein_ok;
    logic         hit;

    assign scan_slot = slot_reg[scan_reg[IW-1:0]];
    assign rein_slot = fbuf_reg[rin_reg[FIRE_IW-1:0]];
    assign can_emit  = !out_valid_reg || !out_stall;
    assign scan_live = (scan_reg < count_reg);
    assign hit       = scan_live && (scan_slot.ident == cmd_reg.beat.timer_id);
    assign fire_due  = (nfire_reg < 5'(MAX_FIRE)) && (count_reg != '0)
                       && (slot_reg[0].expiry <= cmd_reg.beat.now_ms);
    assign rein_ok   = !rein_slot.period[31] && (count_reg < CW'(TIMER_SLOTS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    unique case (pop_work.beat.cmd)
                        CMD_SCHED:
                            state_next = (count_reg >= CW'(TIMER_SLOTS)) ? B_FULL : B_FIND;
                        CMD_CANCEL, CMD_RESET:
                            state_next = B_SEARCH;
                        default:
                            state_next = B_FIRE;
                    endcase
                end
            end
            B_FULL, B_ID, B_DONE, B_SUM:
            begin
                if (can_emit)
                    state_next = B_IDLE;
            end
            B_FIND:
            begin
                if (!(scan_live && scan_slot.expiry <= ins_reg.expiry))
                    state_next = B_INSERT;
            end
            B_INSERT:
                state_next = ret_reg ? B_REIN : B_ID;
            B_SEARCH:
            begin
                if (hit || !scan_live)
                    state_next = B_DONE;
            end
            B_FIRE:
            begin
                if (!fire_due)
                    state_next = B_REIN;
            end
            B_REIN:
            begin
                if (rin_reg == nfire_reg)
                    state_next = B_SUM;
                else if (rein_ok)
                    state_next = B_FIND;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        emit      = 1'b0;
        emit_beat = '0;
        pop_take  = (state_reg == B_IDLE);
        unique case (state_reg)
            B_FULL:
            begin
                emit           = can_emit;
                emit_beat.kind = KIND_FULL;
                emit_beat.last = 1'b1;
            end
            B_ID:
            begin
                emit             = can_emit;
                emit_beat.kind   = KIND_ID;
                emit_beat.out_id = id_reg;
                emit_beat.last   = 1'b1;
            end
            B_DONE:
            begin
                emit           = can_emit;
                emit_beat.kind = KIND_DONE;
                emit_beat.last = 1'b1;
            end
            B_FIRE:
            begin
                emit                  = can_emit && fire_due;
                emit_beat.kind        = KIND_FIRED;
                emit_beat.out_id      = slot_reg[0].ident;
                emit_beat.out_task    = slot_reg[0].tag;
                emit_beat.fire_time_s = cmd_reg.fs;
            end
            B_SUM:
            begin
                emit                    = can_emit;
                emit_beat.kind          = KIND_SUMMARY;
                emit_beat.fire_time_s   = cmd_reg.fs;
                emit_beat.expired_count = nfire_reg;
                emit_beat.last          = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            id_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == B_IDLE && pop_valid && pop_work.beat.cmd == CMD_SCHED
                && count_reg < CW'(TIMER_SLOTS))
                id_reg <= id_reg + 32'd1;
            if (state_reg == B_INSERT)
                count_reg <= count_reg + CW'(1);
            else if ((state_reg == B_SEARCH && hit && cmd_reg.beat.cmd == CMD_CANCEL)
                     || (state_reg == B_FIRE && emit))
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= emit_beat;
        unique case (state_reg)
            B_IDLE:
            begin
                cmd_reg        <= pop_work;
                scan_reg       <= '0;
                nfire_reg      <= '0;
                rin_reg        <= '0;
                ret_reg        <= 1'b0;
                ins_reg.expiry <= sat_add(pop_work.beat.now_ms, {1'b0, pop_work.beat.delay_ms});
                ins_reg.period <= pop_work.beat.period_ms;
                ins_reg.ident  <= id_reg + 32'd1;
                ins_reg.tag    <= pop_work.beat.task_tag;
            end
            B_FIND:
            begin
                if (scan_live && scan_slot.expiry <= ins_reg.expiry)
                    scan_reg <= scan_reg + CW'(1);
            end
            B_INSERT:
            begin
                for (int i = 1; i < TIMER_SLOTS; i++)
                begin
                    if (CW'(i) > scan_reg)
                        slot_reg[i] <= slot_reg[i-1];
                end
                slot_reg[scan_reg[IW-1:0]] <= ins_reg;
            end
            B_SEARCH:
            begin
                if (hit)
                begin
                    if (cmd_reg.beat.cmd == CMD_CANCEL)
                    begin
                        for (int i = 0; i < TIMER_SLOTS - 1; i++)
                        begin
                            if (CW'(i) >= scan_reg)
                                slot_reg[i] <= slot_reg[i+1];
                        end
                    end
                    else
                        slot_reg[scan_reg[IW-1:0]].period <= cmd_reg.beat.period_ms;
                end
                else
                    scan_reg <= scan_reg + CW'(1);
            end
            B_FIRE:
            begin
                if (emit)
                begin
                    fbuf_reg[nfire_reg[FIRE_IW-1:0]] <= slot_reg[0];
                    for (int i = 0; i < TIMER_SLOTS - 1; i++)
                        slot_reg[i] <= slot_reg[i+1];
                    nfire_reg <= nfire_reg + 5'd1;
                end
            end
            B_REIN:
            begin
                if (rin_reg != nfire_reg)
                begin
                    rin_reg        <= rin_reg + 5'd1;
                    scan_reg       <= '0;
                    ret_reg        <= 1'b1;
                    ins_reg.period <= rein_slot.period;
                    ins_reg.ident  <= rein_slot.ident;
                    ins_reg.tag    <= rein_slot.tag;
                    ins_reg.expiry <= sat_add(cmd_reg.beat.now_ms, rein_slot.period);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[sv/stq_checker.sv]
// Port-level checks for the sorted timer queue, bound to the top level.
// Depends on stq_pkg and sorted_timer_queue_unit.
module stq_checker
    import stq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_beat
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_beat))
        else $error("out beat changed while stalled");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.kind == KIND_FIRED |-> !out_beat.last)
        else $error("fired beat marked last");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_beat.kind == KIND_ID || out_beat.kind == KIND_DONE
        || out_beat.kind == KIND_FULL || out_beat.kind == KIND_SUMMARY) |-> out_beat.last)
        else $error("closing beat not marked last");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.kind == KIND_SUMMARY |-> out_beat.expired_count <= 5'(MAX_FIRE))
        else $error("expired count out of range");

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);

[tb/sv/sorted_timer_queue_unit_tb.sv]
// Testbench for sorted_timer_queue_unit: directed table then random commands,
// checked against a behavioral timer table. Depends on stq_pkg and the RTL.
module sorted_timer_queue_unit_tb;
    import stq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 900000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_beat;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_beat;

    sorted_timer_queue_unit #(.TIMER_SLOTS(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
        .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timer table mirror
    logic [47:0] tm_expiry [SLOTS];
    logic [31:0] tm_period [SLOTS];
    logic [31:0] tm_ident  [SLOTS];
    logic [31:0] tm_tag    [SLOTS];
    int          tm_count;
    logic [31:0] next_id;

    out_beat_t pending_results [$];
    int        fail_count;
    int        cycle_count;
    bit        quiet_phase;   // no idling in the last part
    bit        hold_rx;       // long receiver hold-off request

    // directed table: beat, and optionally typed expected first result
    typedef struct {
        in_beat_t  beat;
        bit        has_exp;
        out_beat_t exp;
    } dir_row_t;
    dir_row_t dir_rows [$];

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic out_beat_t mk_result(logic [2:0] k, logic [31:0] id,
                                            logic [31:0] tg, logic [38:0] fs,
                                            logic [4:0] cnt, logic lst);
        out_beat_t r;
        r.kind = k; r.out_id = id; r.out_task = tg;
        r.fire_time_s = fs; r.expired_count = cnt; r.last = lst;
        return r;
    endfunction

    task automatic queue_result(out_beat_t r);
        pending_results = {pending_results, r};
    endtask

    task automatic table_insert(logic [47:0] e, logic [31:0] p, logic [31:0] id,
                                logic [31:0] tg);
        int pos;
        pos = 0;
        while (pos < tm_count && tm_expiry[pos] <= e) pos++;
        for (int i = tm_count; i > pos; i--)
        begin
            tm_expiry[i] = tm_expiry[i-1]; tm_period[i] = tm_period[i-1];
            tm_ident[i] = tm_ident[i-1]; tm_tag[i] = tm_tag[i-1];
        end
        tm_expiry[pos] = e; tm_period[pos] = p; tm_ident[pos] = id; tm_tag[pos] = tg;
        tm_count++;
    endtask

    task automatic table_remove(int pos);
        for (int i = pos; i + 1 < tm_count; i++)
        begin
            tm_expiry[i] = tm_expiry[i+1]; tm_period[i] = tm_period[i+1];
            tm_ident[i] = tm_ident[i+1]; tm_tag[i] = tm_tag[i+1];
        end
        tm_count--;
    endtask

    // apply one command to the mirror, queue up its results
    task automatic predict_timers(in_beat_t b);
        logic [38:0] fs;
        logic [31:0] fp [MAX_FIRE];
        logic [31:0] fi [MAX_FIRE];
        logic [31:0] ft [MAX_FIRE];
        int n;
        case (b.cmd)
            CMD_SCHED:
            begin
                if (tm_count >= SLOTS)
                    queue_result(mk_result(KIND_FULL, '0, '0, '0, '0, 1'b1));
                else
                begin
                    next_id = next_id + 32'd1;
                    table_insert(add_sat(b.now_ms, {1'b0, b.delay_ms}), b.period_ms,
                                 next_id, b.task_tag);
                    queue_result(mk_result(KIND_ID, next_id, '0, '0, '0, 1'b1));
                end
            end
            CMD_CANCEL, CMD_RESET:
            begin
                for (int i = 0; i < tm_count; i++)
                begin
                    if (tm_ident[i] == b.timer_id)
                    begin
                        if (b.cmd == CMD_CANCEL) table_remove(i);
                        else tm_period[i] = b.period_ms;
                        break;
                    end
                end
                queue_result(mk_result(KIND_DONE, '0, '0, '0, '0, 1'b1));
            end
            default:
            begin
                fs = 39'(b.now_ms / 48'd1000);
                n = 0;
                while (n < MAX_FIRE && tm_count > 0 && tm_expiry[0] <= b.now_ms)
                begin
                    fp[n] = tm_period[0]; fi[n] = tm_ident[0]; ft[n] = tm_tag[0];
                    queue_result(mk_result(KIND_FIRED, fi[n], ft[n], fs, '0, 1'b0));
                    table_remove(0);
                    n++;
                end
                for (int i = 0; i < n; i++)
                    if (!fp[i][31] && tm_count < SLOTS)
                        table_insert(add_sat(b.now_ms, fp[i]), fp[i], fi[i], ft[i]);
                queue_result(mk_result(KIND_SUMMARY, '0, '0, fs, n[4:0], 1'b1));
            end
        endcase
    endtask

    // drive one beat, wait for acceptance, predict it; valid stays up
    // after acceptance so back-to-back beats need no extra edge
    task automatic send_beat(in_beat_t b, output int first_idx);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        first_idx = pending_results.size();
        predict_timers(b);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic in_beat_t mk_beat(logic [1:0] c, logic [47:0] now,
                                         logic [30:0] dly, logic [31:0] per,
                                         logic [31:0] id, logic [31:0] tg);
        in_beat_t b;
        b.cmd = c; b.now_ms = now; b.delay_ms = dly; b.period_ms = per;
        b.timer_id = id; b.task_tag = tg;
        return b;
    endfunction

    task automatic add_row(in_beat_t b, bit he, out_beat_t e);
        dir_row_t r;
        r.beat = b; r.has_exp = he; r.exp = e;
        dir_rows = {dir_rows, r};
    endtask

    // recent times, used to keep random commands near live timers
    logic [47:0] clock_ms;

    function automatic in_beat_t rand_beat();
        in_beat_t b;
        int sel;
        b.now_ms = clock_ms;
        b.delay_ms = ($urandom_range(0, 9) == 0) ? 31'($urandom) :
                     31'($urandom_range(0, 400));
        b.period_ms = ($urandom_range(0, 2) == 0) ? 32'($urandom) :
                      32'($urandom_range(0, 300));
        b.task_tag = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 4) b.cmd = CMD_SCHED;
        else if (sel < 6) b.cmd = CMD_CANCEL;
        else if (sel < 7) b.cmd = CMD_RESET;
        else b.cmd = CMD_EXPIRE;
        // aim at live ids most of the time
        if (tm_count > 0 && $urandom_range(0, 4) != 0)
            b.timer_id = tm_ident[$urandom_range(0, tm_count - 1)];
        else
            b.timer_id = $urandom;
        if ($urandom_range(0, 30) == 0) b.now_ms = 48'({$urandom, $urandom});
        return b;
    endfunction

    // receiver: random stall bursts, plus a long hold when requested
    initial
    begin
        int burst;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat kind=%0d", out_beat.kind);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_beat.kind !== e.kind)
                begin
                    $error("kind exp %0d got %0d", e.kind, out_beat.kind); fail_count++;
                end
                if (out_beat.out_id !== e.out_id)
                begin
                    $error("out_id exp %0h got %0h", e.out_id, out_beat.out_id); fail_count++;
                end
                if (out_beat.out_task !== e.out_task)
                begin
                    $error("out_task exp %0h got %0h", e.out_task, out_beat.out_task);
                    fail_count++;
                end
                if (out_beat.fire_time_s !== e.fire_time_s)
                begin
                    $error("fire_time_s exp %0d got %0d", e.fire_time_s,
                           out_beat.fire_time_s);
                    fail_count++;
                end
                if (out_beat.expired_count !== e.expired_count)
                begin
                    $error("expired_count exp %0d got %0d", e.expired_count,
                           out_beat.expired_count);
                    fail_count++;
                end
                if (out_beat.last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, out_beat.last); fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        in_beat_t b;
        out_beat_t none;
        int first_idx;
        fail_count = 0; cycle_count = 0; quiet_phase = 0; hold_rx = 0;
        tm_count = 0; next_id = '0; clock_ms = 48'd5000;
        none = mk_result('0, '0, '0, '0, '0, 1'b0);
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_beat <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-table cases, extremes, saturation, full, wrap-free ids
        add_row(mk_beat(CMD_EXPIRE, 48'd0, '0, '0, '0, '0), 1,
                mk_result(KIND_SUMMARY, '0, '0, '0, '0, 1'b1));
        add_row(mk_beat(CMD_CANCEL, 48'd0, '0, '0, 32'd7, '0), 1,
                mk_result(KIND_DONE, '0, '0, '0, '0, 1'b1));
        add_row(mk_beat(CMD_SCHED, 48'd0, 31'd0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF), 1,
                mk_result(KIND_ID, 32'd1, '0, '0, '0, 1'b1));
        add_row(mk_beat(CMD_SCHED, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                        '0, '0), 1, mk_result(KIND_ID, 32'd2, '0, '0, '0, 1'b1));
        add_row(mk_beat(CMD_RESET, 48'd0, '0, 32'd100, 32'd1, '0), 1,
                mk_result(KIND_DONE, '0, '0, '0, '0, 1'b1));
        add_row(mk_beat(CMD_RESET, 48'd0, '0, 32'd5, 32'hFFFF_FFFF, '0), 1,
                mk_result(KIND_DONE, '0, '0, '0, '0, 1'b1));
        add_row(mk_beat(CMD_EXPIRE, 48'd1999, '0, '0, '0, '0), 0, none);
        add_row(mk_beat(CMD_CANCEL, 48'd0, '0, '0, 32'd1, '0), 0, none);
        // fill the table, due at 3000 to 3002, odd rows repeating
        for (int i = 0; i < 17; i++)
            add_row(mk_beat(CMD_SCHED, 48'd3000, 31'(i % 3),
                            (i % 2 != 0) ? 32'd10 : 32'h8000_0000, '0, 32'(i)), 0, none);
        add_row(mk_beat(CMD_SCHED, 48'd0, '0, '0, '0, '0), 1,
                mk_result(KIND_FULL, '0, '0, '0, '0, 1'b1));
        add_row(mk_beat(CMD_EXPIRE, 48'hFFFF_FFFF_FFFE, '0, '0, '0, '0), 0, none);
        add_row(mk_beat(CMD_EXPIRE, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0), 0, none);

        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].beat, first_idx);
            if (dir_rows[i].has_exp && pending_results[first_idx] != dir_rows[i].exp)
            begin
                $error("directed row %0d: typed result differs from prediction", i);
                fail_count++;
            end
        end
        wait_drained();

        // random part; long receiver hold at about a third
        for (int n = 0; n < 232; n++)
        begin
            if (n == 80)
            begin
                fork
                    begin
                        hold_rx = 1;
                        repeat (600) @(posedge clk);
                        hold_rx = 0;
                    end
                join_none
            end
            if (n == 150)
                wait_drained();     // sender pause until all results are in
            if (n == 200) quiet_phase = 1;
            if ($urandom_range(0, 2) == 0) clock_ms = add_sat(clock_ms, $urandom_range(0, 250));
            b = rand_beat();
            send_beat(b, first_idx);
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
